FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/vmmdp_pkg.sv
// types, constants and helper functions of the voxel depth projection block
`default_nettype none

package vmmdp_pkg;

  localparam int MAP_SIDE = 1024;
  localparam int COORD_W  = $clog2(MAP_SIDE);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int POS_W    = 11;
  localparam int DEPTH_W  = 8;
  localparam int COLOR_W  = 8;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  localparam logic [1:0] SEL_XY = 2'd0;
  localparam logic [1:0] SEL_XZ = 2'd1;
  localparam logic [1:0] SEL_YZ = 2'd2;

  // one map entry, near depth in the lowest byte
  typedef struct packed {
    color_t far_color;
    depth_t far_depth;
    color_t near_color;
    depth_t near_depth;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{far_color: '0, far_depth: '0,
                                     near_color: '0, near_depth: '1};

  typedef struct packed {
    logic   inv;
    entry_t entry;
  } result_t;

  // controls from the top level to one map bank
  typedef struct packed {
    logic   rd_en;
    logic   upd_en;
    logic   clr_en;
    addr_t  clr_addr;
    depth_t depth;
    color_t color;
  } bank_ctl_t;

  function automatic logic coord_ok(input pos_t pos);
    return int'(pos) < MAP_SIDE;
  endfunction

  function automatic addr_t map_addr(input pos_t u, input pos_t v);
    return {COORD_W'(v), COORD_W'(u)};
  endfunction

  // coordinate / 4, saturated to the depth range
  function automatic depth_t proj_depth(input pos_t pos);
    logic [POS_W-3:0] q;
    q = pos[POS_W-1:2];
    return (q[POS_W-3:DEPTH_W] != '0) ? '1 : q[DEPTH_W-1:0];
  endfunction

  function automatic entry_t merge_entry(input entry_t e, input depth_t d,
                                         input color_t c);
    entry_t r;
    r = e;
    if (d <= e.near_depth) begin
      r.near_depth = d;
      r.near_color = c;
    end
    if (d >= e.far_depth) begin
      r.far_depth = d;
      r.far_color = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vmmdp_map_bank.sv
// one projection map: entry memory with read-modify-write and write forwarding
`default_nettype none

module vmmdp_map_bank (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vmmdp_pkg::bank_ctl_t ctl,
  input  wire vmmdp_pkg::addr_t   rd_addr,
  output vmmdp_pkg::entry_t       entry
);
  import vmmdp_pkg::*;

  localparam int ENTRIES = 1 << ADDR_W;

  entry_t mem [ENTRIES];

  entry_t rd_q_r;
  addr_t  rd_addr_r;
  logic   fwd_vld_r;
  addr_t  fwd_addr_r;
  entry_t fwd_data_r;
  entry_t merged;

  // the read was issued in the same edge as the previous write, take that one
  assign entry  = (fwd_vld_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : rd_q_r;
  assign merged = merge_entry(entry, ctl.depth, ctl.color);

  always_ff @(posedge clk) begin
    if (ctl.clr_en) begin
      mem[ctl.clr_addr] <= RESET_ENTRY;
    end else if (ctl.upd_en) begin
      mem[rd_addr_r] <= merged;
    end
    if (ctl.rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= ctl.upd_en;
    end
    fwd_addr_r <= rd_addr_r;
    fwd_data_r <= merged;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_min_max_depth_projection.sv
// voxel min/max depth projection: top level with three map banks and result queue
// a read's result is registered in the merge stage and then in the result queue
// throughput: 1 item per cycle while in_tready is high, one read-modify-write per map bank each cycle,
//   a one-entry forwarding path covers back-to-back hits on the same entry
// reads stall input when the 3-entry result queue plus the read in flight is full
// reset: clearing pass over all 2**(2*clog2(MAP_SIDE)) map entries (1048576), in_tready low
`default_nettype none
`include "assert_macros.svh"

module voxel_min_max_depth_projection (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pos_x[10:0], pos_y[21:11], pos_z[32:22], voxel_color[40:33], zero fill
  input  wire logic [47:0] in_tdata,
  // opcode[0], map_select[2:1]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // near_depth[7:0], near_color[15:8], far_depth[23:16], far_color[31:24]
  output logic [31:0]      out_tdata,
  // addr_invalid
  output logic             out_tuser
);
  import vmmdp_pkg::*;

  localparam int FIFO_DEPTH = 3;
  localparam logic [1:0] PTR_LAST = 2'(FIFO_DEPTH - 1);
  localparam addr_t ADDR_LAST = '1;

  // input fields
  pos_t   pos_x, pos_y, pos_z;
  color_t voxel_color;
  op_t    opcode;
  logic [1:0] map_select;
  logic   in_xfer;

  assign pos_x       = in_tdata[10:0];
  assign pos_y       = in_tdata[21:11];
  assign pos_z       = in_tdata[32:22];
  assign voxel_color = in_tdata[40:33];
  assign opcode      = op_t'(in_tuser[0]);
  assign map_select  = in_tuser[2:1];
  assign in_xfer     = in_tvalid && in_tready;

  // clearing pass
  logic  clr_busy_r;
  addr_t clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // item in the merge stage
  logic   a_vld_r;
  op_t    a_op_r;
  logic [1:0] a_sel_r;
  logic   a_inv_r;
  logic   a_ins_ok_r;
  depth_t a_dxy_r, a_dxz_r, a_dyz_r;
  color_t a_color_r;
  logic   rd_inv;

  always_comb begin
    unique case (map_select)
      SEL_XY:  rd_inv = !(coord_ok(pos_x) && coord_ok(pos_y));
      SEL_XZ:  rd_inv = !(coord_ok(pos_x) && coord_ok(pos_z));
      SEL_YZ:  rd_inv = !(coord_ok(pos_y) && coord_ok(pos_z));
      default: rd_inv = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_xfer;
    end
    if (in_xfer) begin
      a_op_r     <= opcode;
      a_sel_r    <= map_select;
      a_inv_r    <= rd_inv;
      a_ins_ok_r <= coord_ok(pos_x) && coord_ok(pos_y) && coord_ok(pos_z);
      a_dxy_r    <= proj_depth(pos_z);
      a_dxz_r    <= proj_depth(pos_y);
      a_dyz_r    <= proj_depth(pos_x);
      a_color_r  <= voxel_color;
    end
  end

  // map banks
  logic      upd_en;
  bank_ctl_t ctl_xy, ctl_xz, ctl_yz;
  entry_t    ent_xy, ent_xz, ent_yz;

  assign upd_en = a_vld_r && (a_op_r == OP_INSERT) && a_ins_ok_r;

  always_comb begin
    ctl_xy = '{rd_en: in_xfer, upd_en: upd_en, clr_en: clr_busy_r,
               clr_addr: clr_addr_r, depth: a_dxy_r, color: a_color_r};
    ctl_xz = ctl_xy;
    ctl_xz.depth = a_dxz_r;
    ctl_yz = ctl_xy;
    ctl_yz.depth = a_dyz_r;
  end

  vmmdp_map_bank u_xy (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_xy),
    .rd_addr (map_addr(pos_x, pos_y)),
    .entry   (ent_xy)
  );

  vmmdp_map_bank u_xz (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_xz),
    .rd_addr (map_addr(pos_x, pos_z)),
    .entry   (ent_xz)
  );

  vmmdp_map_bank u_yz (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_yz),
    .rd_addr (map_addr(pos_y, pos_z)),
    .entry   (ent_yz)
  );

  // result selection
  result_t res;

  always_comb begin
    res.inv = a_inv_r;
    unique case (a_sel_r)
      SEL_XY:  res.entry = ent_xy;
      SEL_XZ:  res.entry = ent_xz;
      SEL_YZ:  res.entry = ent_yz;
      default: res.entry = '0;
    endcase
    if (a_inv_r) begin
      res.entry = '0;
    end
  end

  // result queue
  result_t    fifo_r [FIFO_DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r, cnt_r;
  logic       push, pop, pending;

  assign pending    = a_vld_r && (a_op_r == OP_READ);
  assign push       = pending;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = fifo_r[rd_ptr_r].entry;
  assign out_tuser  = fifo_r[rd_ptr_r].inv;

  // room must remain for the read in flight and the one accepted now
  assign in_tready = !clr_busy_r && (({1'b0, cnt_r} + {2'b0, pending}) <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? 2'd0 : wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? 2'd0 : rd_ptr_r + 2'd1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  `ASSERT_CLK(a_fifo_no_overflow, (push && !pop) |-> (cnt_r != 2'(FIFO_DEPTH)), "result queue overflow")
  `ASSERT_CLK_ALWAYS(a_no_update_in_clear, clr_busy_r |-> !upd_en, "map update during clearing pass")
  `ASSERT_CLK(a_clear_complete, $fell(clr_busy_r) |-> ($past(clr_addr_r) == ADDR_LAST), "clearing pass ended early")

endmodule

`default_nettype wire
